// ===== hdl/ordered_list_append_delete_assert.svh =====
// Assertion macros for the ordered list block.
// Used by ordered_list_append_delete.sv; expects clk and arst_n in scope.
`ifndef ORDERED_LIST_APPEND_DELETE_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_ASSERT_SVH

// Expression holds at every clock edge outside reset.
`define OLAD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define OLAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/olad_pkg.sv =====
// Shared types and constants for the ordered list block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package olad_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Field widths of the channels
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND   = 2'd0,
		OP_DEL_HEAD = 2'd1,
		OP_DEL_TAIL = 2'd2,
		OP_DEL_AT   = 2'd3
	} olad_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} olad_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CAPTURE,
		S_SHIFT
	} olad_state_t;

endpackage

`default_nettype wire

// ===== hdl/olad_req_if.sv =====
// Request channel: valid/ready handshake with operation, value and position.
// Depends on olad_pkg for field widths.
`default_nettype none

interface olad_req_if;
	logic                              valid;
	logic                              ready;
	logic [olad_pkg::OP_W-1:0]         op;
	logic signed [olad_pkg::VALUE_W-1:0] value;
	logic [olad_pkg::POS_W-1:0]        position;

	modport source(output valid, output op, output value, output position, input ready);
	modport sink(input valid, input op, input value, input position, output ready);
endinterface

`default_nettype wire

// ===== hdl/olad_rsp_if.sv =====
// Response channel: valid/ready handshake with status, removed value and count.
// Depends on olad_pkg for field widths.
`default_nettype none

interface olad_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [olad_pkg::STATUS_W-1:0]       status;
	logic signed [olad_pkg::VALUE_W-1:0] removed_value;
	logic [olad_pkg::COUNT_W-1:0]        entry_count;

	modport source(output valid, output status, output removed_value, output entry_count,
		input ready);
	modport sink(input valid, input status, input removed_value, input entry_count,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/ordered_list_append_delete.sv =====
// Bounded ordered list with append and delete, held in one synchronous RAM.
// Depends on olad_pkg, olad_req_if, olad_rsp_if and the assertion header.
//
//  channel | modport | payload                                  | dir
//  req     | sink    | op, value, position                      | in
//  rsp     | source  | status, removed_value, entry_count       | out
//
// Append and every ignored operation: result registered at the accept edge.
// Delete: S_CAPTURE takes the removed entry, then S_SHIFT moves down any entries behind it;
// the single RAM write port moves one entry per cycle while closing the gap.
// Reset clears the count and control only; the RAM holds no reset value and
// needs no clearing pass.
// req.ready is high in idle while the result register is empty or being drained;
// a stalled rsp holds its result and blocks the next request only.
`default_nettype none

module ordered_list_append_delete (
	input  wire logic   clk,
	input  wire logic   arst_n,
	olad_req_if.sink    req,
	olad_rsp_if.source  rsp
);

	localparam int IW = olad_pkg::IDX_W;
	localparam int CW = olad_pkg::CNT_W;
	localparam int DW = olad_pkg::DATA_WIDTH;

	// Entry storage
	logic signed [DW-1:0] mem [olad_pkg::CAPACITY];
	logic signed [DW-1:0] rd_data_q;
	logic [IW-1:0]        rd_addr;
	logic [IW-1:0]        wr_addr;
	logic signed [DW-1:0] wr_data;
	logic                 mem_we;

	// Control
	olad_pkg::olad_state_t state_q, state_nxt;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         wr_idx_q;
	logic [IW-1:0]         last_q;
	logic signed [DW-1:0]  removed_q;

	// Result register
	logic                          out_valid_q;
	olad_pkg::olad_status_t        out_status_q;
	logic signed [olad_pkg::VALUE_W-1:0] out_removed_q;
	logic [olad_pkg::COUNT_W-1:0]  out_count_q;

	// Decode of the request at the accept edge
	logic                   acc;
	logic                   is_append;
	logic                   list_full;
	logic                   list_empty;
	logic                   pos_bad;
	olad_pkg::olad_status_t status_now;
	logic [IW-1:0]          del_idx;
	logic                   start_del;
	logic                   imm_done;

	// Work completion
	logic                   work_done;
	logic signed [DW-1:0]   work_removed;
	logic                   out_load;

	assign req.ready = (state_q == olad_pkg::S_IDLE) && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	// Request decode
	always_comb begin
		is_append  = (req.op == olad_pkg::OP_APPEND);
		list_full  = (count_q == CW'(olad_pkg::CAPACITY));
		list_empty = (count_q == '0);
		pos_bad    = (req.position == '0) ||
			(req.position > olad_pkg::POS_W'(count_q));
		priority if (is_append) begin
			status_now = list_full ? olad_pkg::STAT_FULL : olad_pkg::STAT_DONE;
		end else if (list_empty) begin
			status_now = olad_pkg::STAT_EMPTY;
		end else if (req.op == olad_pkg::OP_DEL_AT && pos_bad) begin
			status_now = olad_pkg::STAT_RANGE;
		end else begin
			status_now = olad_pkg::STAT_DONE;
		end
		unique case (req.op)
			olad_pkg::OP_DEL_HEAD: del_idx = '0;
			olad_pkg::OP_DEL_TAIL: del_idx = IW'(count_q - CW'(1));
			olad_pkg::OP_DEL_AT:   del_idx = IW'(req.position - olad_pkg::POS_W'(1));
			default:               del_idx = '0;
		endcase
		start_del = acc && !is_append && (status_now == olad_pkg::STAT_DONE);
		imm_done  = acc && !start_del;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			olad_pkg::S_IDLE: begin
				if (start_del) state_nxt = olad_pkg::S_CAPTURE;
			end
			olad_pkg::S_CAPTURE: begin
				state_nxt = (wr_idx_q == last_q) ? olad_pkg::S_IDLE : olad_pkg::S_SHIFT;
			end
			olad_pkg::S_SHIFT: begin
				if (IW'(wr_idx_q + IW'(1)) == last_q) state_nxt = olad_pkg::S_IDLE;
			end
			default: state_nxt = olad_pkg::S_IDLE;
		endcase
	end

	// RAM port control and completion
	always_comb begin
		rd_addr      = del_idx;
		wr_addr      = IW'(count_q);
		wr_data      = DW'(req.value);
		mem_we       = 1'b0;
		work_done    = 1'b0;
		work_removed = removed_q;
		unique case (state_q)
			olad_pkg::S_IDLE: begin
				mem_we = acc && is_append && !list_full;
			end
			olad_pkg::S_CAPTURE: begin
				// read data is the removed entry; fetch the one behind it
				rd_addr      = IW'(wr_idx_q + IW'(1));
				work_removed = rd_data_q;
				work_done    = (wr_idx_q == last_q);
			end
			olad_pkg::S_SHIFT: begin
				// move entry wr_idx+1 down to wr_idx, prefetch wr_idx+2
				rd_addr   = IW'(wr_idx_q + IW'(2));
				wr_addr   = wr_idx_q;
				wr_data   = rd_data_q;
				mem_we    = 1'b1;
				work_done = (IW'(wr_idx_q + IW'(1)) == last_q);
			end
			default: ;
		endcase
		out_load = imm_done || work_done;
	end

	// Entry RAM, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olad_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc && is_append && !list_full) begin
				count_q <= count_q + CW'(1);
			end else if (work_done) begin
				count_q <= count_q - CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Work registers and result payload
	always_ff @(posedge clk) begin
		if (start_del) begin
			wr_idx_q <= del_idx;
			last_q   <= IW'(count_q - CW'(1));
		end else if (state_q == olad_pkg::S_SHIFT) begin
			wr_idx_q <= IW'(wr_idx_q + IW'(1));
		end
		if (state_q == olad_pkg::S_CAPTURE) removed_q <= rd_data_q;
		if (imm_done) begin
			out_status_q  <= status_now;
			out_removed_q <= '0;
			out_count_q   <= (is_append && !list_full) ?
				olad_pkg::COUNT_W'(count_q + CW'(1)) : olad_pkg::COUNT_W'(count_q);
		end else if (work_done) begin
			out_status_q  <= olad_pkg::STAT_DONE;
			out_removed_q <= olad_pkg::VALUE_W'(work_removed);
			out_count_q   <= olad_pkg::COUNT_W'(count_q - CW'(1));
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.removed_value = out_removed_q;
	assign rsp.entry_count   = out_count_q;

	// Checks
	`include "ordered_list_append_delete_assert.svh"

	`OLAD_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(olad_pkg::CAPACITY), "count above capacity")
	`OLAD_ASSERT_ALWAYS(a_busy_out_free, (state_q == olad_pkg::S_IDLE) || !out_valid_q, "result register busy during delete")
	`OLAD_ASSERT_ALWAYS(a_shift_order, (state_q != olad_pkg::S_SHIFT) || (wr_idx_q < last_q), "shift past last entry")
	`OLAD_ASSERT_NEXT(a_count_hold, !out_load, $stable(count_q), "count moved without a result")

endmodule

`default_nettype wire

// ===== test/olad_list_checker.sv =====
// Checker for the ordered list block: watches both channels, predicts each result and compares.
// Depends on olad_pkg, olad_req_if and olad_rsp_if; instantiated by tb_ordered_list_append_delete.
`default_nettype none

module olad_list_checker
	import olad_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	olad_req_if         req,
	olad_rsp_if         rsp,
	output int unsigned mismatch_count,
	output int unsigned pending_results,
	output int unsigned checked_results,
	output int unsigned status_hits [4]
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_PRINTED = 30;

	typedef struct packed {
		olad_status_t              status;
		logic signed [VALUE_W-1:0] removed_value;
		logic [COUNT_W-1:0]        entry_count;
	} list_result_t;

	// Shadow of the list contents, first entry at index 0
	logic signed [DATA_WIDTH-1:0] held_values [$];
	list_result_t                 expected_results [$];

	// Apply one operation to the shadow list and return the result it should produce
	function automatic list_result_t apply_list_op(olad_op_t op, logic signed [VALUE_W-1:0] value,
		logic [POS_W-1:0] position);
		list_result_t res;
		res.status        = STAT_DONE;
		res.removed_value = '0;
		if (op == OP_APPEND) begin
			if (held_values.size() >= CAPACITY)
				res.status = STAT_FULL;
			else
				held_values.push_back(value[DATA_WIDTH-1:0]);
		end else if (held_values.size() == 0) begin
			res.status = STAT_EMPTY;
		end else begin
			case (op)
				OP_DEL_HEAD: res.removed_value = held_values.pop_front();
				OP_DEL_TAIL: res.removed_value = held_values.pop_back();
				default: begin
					// position is 1-based; zero and anything past the tail are rejected
					if (position == 0 || position > held_values.size()) begin
						res.status = STAT_RANGE;
					end else begin
						res.removed_value = held_values[position - 1];
						held_values.delete(position - 1);
					end
				end
			endcase
		end
		res.entry_count = COUNT_W'(held_values.size());
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("[%0t] olad check: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Compare each result transfer against the oldest expectation, then log new requests
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			held_values.delete();
			expected_results.delete();
			mismatch_count  <= 0;
			pending_results <= 0;
			checked_results <= 0;
			foreach (status_hits[i])
				status_hits[i] <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with nothing pending", rsp.entry_count, 0);
				end else begin
					want = expected_results.pop_front();
					checked_results <= checked_results + 1;
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.removed_value !== want.removed_value)
						report_mismatch("removed_value", rsp.removed_value, want.removed_value);
					if (rsp.entry_count !== want.entry_count)
						report_mismatch("entry_count", rsp.entry_count, want.entry_count);
				end
			end
			if (req.valid && req.ready) begin
				want = apply_list_op(olad_op_t'(req.op), req.value, req.position);
				expected_results.push_back(want);
				status_hits[want.status] <= status_hits[want.status] + 1;
			end
			pending_results <= expected_results.size();
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_ordered_list_append_delete.sv =====
// Top of the ordered list testbench: clock, reset, request stimulus, result stalls, verdict.
// Depends on olad_pkg, both channel interfaces, the block and olad_list_checker.
`default_nettype none

module tb_ordered_list_append_delete;
	timeunit 1ns;
	timeprecision 1ps;
	import olad_pkg::*;

	localparam int          CLK_PERIOD     = 20;
	localparam int          RESET_CYCLES   = 7;
	localparam int unsigned RANDOM_ITEMS   = 1935;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int          DRAIN_CYCLES   = 40;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;
	typedef enum {RX_OPEN, RX_COIN, RX_LONG, RX_TOGGLE} rx_mode_t;

	logic clk;
	logic arst_n   = 1'b0;
	logic rx_ready = 1'b0;

	int unsigned mismatch_count;
	int unsigned pending_results;
	int unsigned checked_results;
	int unsigned status_hits [4];

	olad_req_if req_ch();
	olad_rsp_if rsp_ch();

	assign rsp_ch.ready = rx_ready;

	ordered_list_append_delete DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	olad_list_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results),
		.checked_results (checked_results),
		.status_hits     (status_hits)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Result side stalls: a mode is held for a while, then another is drawn
	rx_mode_t    rx_mode   = RX_OPEN;
	int unsigned rx_left   = 0;
	int unsigned stall_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(30, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN: rx_ready <= 1'b1;
				RX_COIN: rx_ready <= ($urandom_range(0, 3) != 0);
				RX_LONG: begin
					if (stall_left != 0) begin
						rx_ready   <= 1'b0;
						stall_left <= stall_left - 1;
					end else begin
						rx_ready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							stall_left <= $urandom_range(1, 24);
					end
				end
				default: rx_ready <= ~rx_ready;
			endcase
		end
	end

	// Watchdog: too many cycles without any transfer ends the run
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results pending",
				idle_cycles, pending_results);
			$display("tb_ordered_list_append_delete NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Request side state
	int unsigned burst_left   = 0;
	int unsigned list_size    = 0;
	int unsigned sent_count   = 0;
	op_mix_t     op_mix       = MIX_EVEN;
	int unsigned mix_left     = 0;

	// One request transfer; idles between bursts of random length first
	task automatic issue_request(olad_op_t op, logic [VALUE_W-1:0] value,
		logic [POS_W-1:0] position);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.value    <= value;
		req_ch.position <= position;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent_count++;
		// track the size only, to aim positions at the live range
		if (op == OP_APPEND) begin
			if (list_size < CAPACITY)
				list_size++;
		end else if (list_size != 0 &&
			(op != OP_DEL_AT || (position >= 1 && position <= list_size))) begin
			list_size--;
		end
	endtask

	function automatic olad_op_t pick_op();
		int unsigned roll;
		int unsigned append_pct;
		roll = $urandom_range(0, 99);
		case (op_mix)
			MIX_GROW:   append_pct = 75;
			MIX_SHRINK: append_pct = 25;
			default:    append_pct = 50;
		endcase
		if (roll < append_pct)
			return OP_APPEND;
		return olad_op_t'($urandom_range(1, 3));
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly inside 1..size, with zero, the tail, one past the tail and anything at all
	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return POS_W'(list_size + 1);
			2:       return POS_W'($urandom_range(0, 255));
			3:       return POS_W'(list_size);
			default: return POS_W'($urandom_range(1, (list_size == 0) ? 1 : list_size));
		endcase
	endfunction

	initial begin
		int unsigned n;
		req_ch.valid    <= 1'b0;
		req_ch.op       <= OP_APPEND;
		req_ch.value    <= '0;
		req_ch.position <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Deletes on the empty list
		issue_request(OP_DEL_HEAD, 32'h0, 8'd1);
		issue_request(OP_DEL_TAIL, 32'hFFFF_FFFF, 8'd1);
		issue_request(OP_DEL_AT, 32'h0, 8'd0);
		issue_request(OP_DEL_AT, 32'h0, 8'd255);
		// Value extremes
		issue_request(OP_APPEND, 32'h8000_0000, 8'd255);
		issue_request(OP_APPEND, 32'h7FFF_FFFF, 8'd0);
		issue_request(OP_APPEND, 32'h0000_0000, 8'd1);
		issue_request(OP_APPEND, 32'hFFFF_FFFF, 8'd2);
		// Positions out of range, then in the middle and at the tail; then delete tail and head
		issue_request(OP_DEL_AT, 32'h0, 8'd0);
		issue_request(OP_DEL_AT, 32'h0, 8'd5);
		issue_request(OP_DEL_AT, 32'h0, 8'd255);
		issue_request(OP_DEL_AT, 32'h0, 8'd2);
		issue_request(OP_DEL_AT, 32'h0, 8'd3);
		issue_request(OP_DEL_TAIL, 32'h0, 8'd0);
		issue_request(OP_DEL_HEAD, 32'h0, 8'd0);

		// Random phases that fill, drain or churn the list
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (mix_left == 0) begin
				op_mix   = op_mix_t'($urandom_range(0, 2));
				mix_left = $urandom_range(20, 60);
			end
			mix_left--;
			issue_request(pick_op(), pick_value(), pick_position());
		end
		req_ch.valid <= 1'b0;
		@(posedge clk);

		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d requests sent, %0d results checked, %0d mismatches",
			sent_count, checked_results, mismatch_count);
		$display("outcomes: %0d done, %0d empty, %0d full, %0d position out of range",
			status_hits[STAT_DONE], status_hits[STAT_EMPTY], status_hits[STAT_FULL],
			status_hits[STAT_RANGE]);
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("tb_ordered_list_append_delete OK");
		end else begin
			$display("tb_ordered_list_append_delete NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
